// File: design/rcm_pkg.sv
// Shared types and constants for the radius contact marker.
// Used by every module of the block and by the port checker.
package rcm_pkg;

   localparam int MAX_ATOMS    = 4096;
   localparam int MAX_RESIDUES = 1024;

   localparam int ATOM_AW = $clog2(MAX_ATOMS);
   localparam int ATOM_CW = $clog2(MAX_ATOMS + 1);
   localparam int RES_AW  = $clog2(MAX_RESIDUES);
   localparam int RES_CW  = $clog2(MAX_RESIDUES + 1);

   localparam int COORD_W = 20;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int THR_W   = 44;
   localparam int TOP_W   = 13;
   localparam int GROUP_W = 12;
   localparam int INDEX_W = 12;
   localparam int CNT_W   = 13;
   localparam int CSR_W   = 44;
   localparam int CSR_AW  = 1;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(1081600);
   localparam logic [TOP_W-1:0] TOP_RESET = TOP_W'(4096);

   localparam logic [CSR_AW-1:0] CSR_THRESHOLD = 1'd0;
   localparam logic [CSR_AW-1:0] CSR_TOP       = 1'd1;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_QUERY = 2'd1,
      ACT_READ  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_RANGE   = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_READ,
      FSM_SCAN,
      FSM_CLEAR
   } fsm_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      action_type           action;
      coord_type            coord_x;
      coord_type            coord_y;
      coord_type            coord_z;
      logic                 new_residue;
      logic [GROUP_W-1:0]   group_number;
      logic [INDEX_W-1:0]   read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [CNT_W-1:0] newly_marked;
      logic             atom_marked;
      logic             residue_marked;
   } rsp_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } query_type;

   // one atom store word: mark bit kept beside the position
   typedef struct packed {
      logic              mark;
      logic [RES_AW-1:0] residue;
      coord_type         z;
      coord_type         y;
      coord_type         x;
   } entry_type;

   typedef struct packed {
      logic               atom_we;
      logic [ATOM_AW-1:0] atom_waddr;
      entry_type          atom_wdata;
      logic [ATOM_AW-1:0] atom_raddr;
      logic               res_we;
      logic [RES_AW-1:0]  res_waddr;
      logic               res_wdata;
      logic [RES_AW-1:0]  res_raddr;
   } mem_cmd_type;

   typedef struct packed {
      logic               valid;
      logic               hit;
      entry_type          entry;
      logic [ATOM_AW-1:0] addr;
   } hit_type;

endpackage

// File: design/rcm_store.sv
// Atom store and residue mark memories, one write and one read port each,
// read data registered. Depends on rcm_pkg.
module rcm_store
   import rcm_pkg::*;
(
   input  logic        clock,
   input  mem_cmd_type mem_cmd,
   output entry_type   atom_rd,
   output logic        res_rd
);

   entry_type atom_mem [MAX_ATOMS];
   logic      res_mem  [MAX_RESIDUES];

   entry_type atom_rd_ff;
   logic      res_rd_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.atom_we) begin
         atom_mem[mem_cmd.atom_waddr] <= mem_cmd.atom_wdata;
      end
      atom_rd_ff <= atom_mem[mem_cmd.atom_raddr];
   end

   always_ff @(posedge clock) begin
      if (mem_cmd.res_we) begin
         res_mem[mem_cmd.res_waddr] <= mem_cmd.res_wdata;
      end
      res_rd_ff <= res_mem[mem_cmd.res_raddr];
   end

   assign atom_rd = atom_rd_ff;
   assign res_rd  = res_rd_ff;

endmodule

// File: design/rcm_dist.sv
// Distance stage of the scan: squares registered, then sum and compare.
// Depends on rcm_pkg.
module rcm_dist
   import rcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_valid,
   input  entry_type          rd_entry,
   input  logic [ATOM_AW-1:0] rd_addr,
   input  query_type          query,
   input  logic [THR_W-1:0]   threshold,
   output hit_type            hit
);

   logic signed [DIFF_W-1:0] dx, dy, dz;
   logic signed [SQ_W-1:0]   px, py, pz;
   logic [SQ_W-1:0]          sum;

   logic               valid_ff;
   logic [SQ_W-1:0]    sqx_ff, sqy_ff, sqz_ff;
   entry_type          entry_ff;
   logic [ATOM_AW-1:0] addr_ff;

   always_comb begin
      dx = DIFF_W'(query.x) - DIFF_W'(rd_entry.x);
      dy = DIFF_W'(query.y) - DIFF_W'(rd_entry.y);
      dz = DIFF_W'(query.z) - DIFF_W'(rd_entry.z);
      px = dx * dx;
      py = dy * dy;
      pz = dz * dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= rd_valid;
      end
   end

   always_ff @(posedge clock) begin
      sqx_ff   <= $unsigned(px);
      sqy_ff   <= $unsigned(py);
      sqz_ff   <= $unsigned(pz);
      entry_ff <= rd_entry;
      addr_ff  <= rd_addr;
   end

   // each square is below 2^40, so three of them fit the product width
   always_comb begin
      sum       = sqx_ff + sqy_ff + sqz_ff;
      hit.valid = valid_ff;
      hit.hit   = valid_ff && !entry_ff.mark && (THR_W'(sum) < threshold);
      hit.entry = entry_ff;
      hit.addr  = addr_ff;
   end

endmodule

// File: design/rcm_ctrl.sv
// Sequencer: command decode, config registers, store scan and clear sweep,
// result register. Depends on rcm_pkg.
module rcm_ctrl
   import rcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   input  req_type            req_data,
   output logic               busy,
   output logic               rsp_strobe,
   output rsp_type            rsp_data,
   input  logic               csr_we,
   input  logic [CSR_AW-1:0]  csr_index,
   input  logic [CSR_W-1:0]   csr_wdata,
   output mem_cmd_type        mem_cmd,
   input  entry_type          atom_rd,
   input  logic               res_rd,
   input  hit_type            hit,
   output logic               rd_valid,
   output logic [ATOM_AW-1:0] rd_addr,
   output query_type          query,
   output logic [THR_W-1:0]   threshold
);

   fsm_type            state_ff, state_in;
   logic [ATOM_CW-1:0] addr_ff, addr_in;
   logic               v1_ff, v1_in;
   logic [ATOM_AW-1:0] addr1_ff, addr1_in;
   logic [CNT_W-1:0]   newly_ff, newly_in;
   query_type          query_ff, query_in;
   logic [INDEX_W-1:0] read_idx_ff, read_idx_in;
   logic [ATOM_CW-1:0] atom_count_ff, atom_count_in;
   logic [RES_CW-1:0]  residue_count_ff, residue_count_in;
   logic [THR_W-1:0]   thr_ff, thr_in;
   logic [TOP_W-1:0]   top_ff, top_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;

   logic              accept;
   logic              opens;
   logic              full;
   logic              issue;
   logic [RES_AW-1:0] res_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= FSM_IDLE;
         v1_ff            <= 1'b0;
         atom_count_ff    <= '0;
         residue_count_ff <= '0;
         thr_ff           <= THR_RESET;
         top_ff           <= TOP_RESET;
         rsp_strobe_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         v1_ff            <= v1_in;
         atom_count_ff    <= atom_count_in;
         residue_count_ff <= residue_count_in;
         thr_ff           <= thr_in;
         top_ff           <= top_in;
         rsp_strobe_ff    <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      addr1_ff    <= addr1_in;
      newly_ff    <= newly_in;
      query_ff    <= query_in;
      read_idx_ff <= read_idx_in;
      rsp_ff      <= rsp_in;
   end

   // config port; the user must write it only while idle, the block itself does not enforce it
   always_comb begin
      thr_in = thr_ff;
      top_in = top_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: thr_in = csr_wdata[THR_W-1:0];
            CSR_TOP:       top_in = csr_wdata[TOP_W-1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      accept = req_start && (state_ff == FSM_IDLE);
      opens  = req_data.new_residue || (atom_count_ff == '0);
      full   = (atom_count_ff == ATOM_CW'(MAX_ATOMS))
               || (opens && (residue_count_ff == RES_CW'(MAX_RESIDUES)));
      res_idx = opens ? RES_AW'(residue_count_ff)
                      : RES_AW'(residue_count_ff - RES_CW'(1));
      issue  = addr_ff < atom_count_ff;

      state_in         = state_ff;
      addr_in          = addr_ff;
      v1_in            = 1'b0;
      addr1_in         = addr_ff[ATOM_AW-1:0];
      newly_in         = newly_ff;
      query_in         = query_ff;
      read_idx_in      = read_idx_ff;
      atom_count_in    = atom_count_ff;
      residue_count_in = residue_count_ff;
      rsp_strobe_in    = 1'b0;
      rsp_in           = '0;

      mem_cmd            = '0;
      mem_cmd.atom_raddr = ATOM_AW'(req_data.read_index);
      mem_cmd.res_raddr  = RES_AW'(req_data.read_index);

      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  ACT_LOAD: begin
                     rsp_strobe_in = 1'b1;
                     if (full) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        mem_cmd.atom_we            = 1'b1;
                        mem_cmd.atom_waddr         = atom_count_ff[ATOM_AW-1:0];
                        mem_cmd.atom_wdata.mark    = 1'b0;
                        mem_cmd.atom_wdata.residue = res_idx;
                        mem_cmd.atom_wdata.x       = req_data.coord_x;
                        mem_cmd.atom_wdata.y       = req_data.coord_y;
                        mem_cmd.atom_wdata.z       = req_data.coord_z;
                        // a fresh residue starts unmarked
                        mem_cmd.res_we    = opens;
                        mem_cmd.res_waddr = res_idx;
                        mem_cmd.res_wdata = 1'b0;
                        atom_count_in     = atom_count_ff + ATOM_CW'(1);
                        if (opens) begin
                           residue_count_in = residue_count_ff + RES_CW'(1);
                        end
                     end
                  end
                  ACT_QUERY: begin
                     if (TOP_W'(req_data.group_number) >= top_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ST_IGNORED;
                     end else if (atom_count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in   = FSM_SCAN;
                        addr_in    = '0;
                        newly_in   = '0;
                        query_in.x = req_data.coord_x;
                        query_in.y = req_data.coord_y;
                        query_in.z = req_data.coord_z;
                     end
                  end
                  ACT_READ: begin
                     if (32'(req_data.read_index) >= 32'(atom_count_ff)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ST_RANGE;
                     end else begin
                        state_in    = FSM_READ;
                        read_idx_in = req_data.read_index;
                     end
                  end
                  ACT_CLEAR: begin
                     if (atom_count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = FSM_CLEAR;
                        addr_in  = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end

         FSM_READ: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.atom_marked = atom_rd.mark;
            rsp_in.residue_marked =
               (32'(read_idx_ff) < 32'(residue_count_ff)) ? res_rd : 1'b0;
            state_in = FSM_IDLE;
         end

         FSM_SCAN: begin
            mem_cmd.atom_raddr = addr_ff[ATOM_AW-1:0];
            v1_in = issue;
            if (issue) begin
               addr_in = addr_ff + ATOM_CW'(1);
            end
            // read slot runs two entries ahead of write-back, no overlap
            if (hit.hit) begin
               mem_cmd.atom_we         = 1'b1;
               mem_cmd.atom_waddr      = hit.addr;
               mem_cmd.atom_wdata      = hit.entry;
               mem_cmd.atom_wdata.mark = 1'b1;
               mem_cmd.res_we          = 1'b1;
               mem_cmd.res_waddr       = hit.entry.residue;
               mem_cmd.res_wdata       = 1'b1;
               newly_in                = newly_ff + CNT_W'(1);
            end
            if (!issue && !v1_ff && !hit.valid) begin
               rsp_strobe_in       = 1'b1;
               rsp_in.newly_marked = newly_ff;
               state_in            = FSM_IDLE;
            end
         end

         FSM_CLEAR: begin
            mem_cmd.atom_raddr = addr_ff[ATOM_AW-1:0];
            v1_in = issue;
            if (issue) begin
               addr_in = addr_ff + ATOM_CW'(1);
            end
            // residues below the count sit at indexes below the atom count
            if (issue && (32'(addr_ff) < 32'(residue_count_ff))) begin
               mem_cmd.res_we    = 1'b1;
               mem_cmd.res_waddr = RES_AW'(addr_ff);
               mem_cmd.res_wdata = 1'b0;
            end
            if (v1_ff) begin
               mem_cmd.atom_we         = 1'b1;
               mem_cmd.atom_waddr      = addr1_ff;
               mem_cmd.atom_wdata      = atom_rd;
               mem_cmd.atom_wdata.mark = 1'b0;
            end
            if (!issue && !v1_ff) begin
               rsp_strobe_in = 1'b1;
               state_in      = FSM_IDLE;
            end
         end

         default: state_in = FSM_IDLE;
      endcase
   end

   assign busy       = (state_ff != FSM_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign rd_valid   = v1_ff && (state_ff == FSM_SCAN);
   assign rd_addr    = addr1_ff;
   assign query      = query_ff;
   assign threshold  = thr_ff;

endmodule

// File: design/radius_contact_marker_top.sv
// Radius contact marker: load atoms, mark those within a radius of query points.
// Loads, rejected reads, ignored queries, and queries or clears on an empty store answer
// directly; query and clear scan the store one entry per cycle.
// One command at a time, next one taken in the cycle its result shows; results cannot be held off.
// Synchronous active-high reset clears counts, sequencer state and config; loads rewrite entries.
// Depends on rcm_pkg, rcm_ctrl, rcm_store, rcm_dist.
module radius_contact_marker_top
   import rcm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_start,
   input  req_type           req_data,
   output logic              busy,
   output logic              rsp_strobe,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   mem_cmd_type        mem_cmd;
   entry_type          atom_rd;
   logic               res_rd;
   hit_type            hit;
   logic               rd_valid;
   logic [ATOM_AW-1:0] rd_addr;
   query_type          query;
   logic [THR_W-1:0]   threshold;

   rcm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_start  (req_start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mem_cmd    (mem_cmd),
      .atom_rd    (atom_rd),
      .res_rd     (res_rd),
      .hit        (hit),
      .rd_valid   (rd_valid),
      .rd_addr    (rd_addr),
      .query      (query),
      .threshold  (threshold)
   );

   rcm_store u_store (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .atom_rd (atom_rd),
      .res_rd  (res_rd)
   );

   rcm_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .rd_valid  (rd_valid),
      .rd_entry  (atom_rd),
      .rd_addr   (rd_addr),
      .query     (query),
      .threshold (threshold),
      .hit       (hit)
   );

endmodule

// File: design/rcm_checker.sv
// Port-level checks for the radius contact marker, bound to the top level.
// Depends on rcm_pkg.
module rcm_checker
   import rcm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_start,
   input req_type req_data,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // a load always answers in the next beat
   a_load_resp: assert property (@(posedge clock) disable iff (reset)
      req_start && !busy && (req_data.action == ACT_LOAD) |=> rsp_strobe)
      else $error("load without result");

   // a long command ends with its result as busy drops
   a_done_resp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_strobe)
      else $error("busy dropped without result");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result while busy");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && ((rsp_data.status == ST_IGNORED) || (rsp_data.status == ST_RANGE))
      |-> (rsp_data.newly_marked == '0) && !rsp_data.atom_marked
          && !rsp_data.residue_marked)
      else $error("fields set on rejected command");

endmodule

bind radius_contact_marker_top rcm_checker u_rcm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_start  (req_start),
   .req_data   (req_data),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
